### design/wma_pkg.sv
`default_nettype none

package wma_pkg;

    // window depth and field widths
    localparam int WINDOW   = 5;
    localparam int SAMPLE_W = 16;
    localparam int FILL_W   = 3;
    localparam int MEAN_W   = 24;
    localparam int FRAC_W   = 8;

    // derived widths
    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SAMPLE_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
    localparam int DVD_W    = SUM_W + FRAC_W;
    localparam int STEP_W   = $clog2(DVD_W + 1);

    // top level control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } wma_state_t;

    // divider status toward the control
    typedef struct packed {
        logic busy;
        logic done;
    } wma_div_stat_t;

endpackage : wma_pkg

`default_nettype wire

### design/wma_window.sv
`default_nettype none

module wma_window
    import wma_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire logic [SAMPLE_W-1:0] sample,
    output logic      [SUM_W-1:0]    sum_next,
    output logic      [CNT_W-1:0]    held_next,
    output logic      [CNT_W-1:0]    held_count
);

    logic [SAMPLE_W-1:0] store_reg [WINDOW];
    logic [SLOT_W-1:0]   oldest_reg;
    logic [SLOT_W-1:0]   oldest_next;
    logic [CNT_W-1:0]    held_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] old_value;
    logic                full;

    // pick the slot: next free one while filling, oldest one once full
    always_comb begin
        full      = (held_reg == CNT_W'(WINDOW));
        slot      = full ? oldest_reg : held_reg[SLOT_W-1:0];
        old_value = store_reg[slot];
        if (full) begin
            oldest_next = (oldest_reg == SLOT_W'(WINDOW - 1)) ? '0 : oldest_reg + 1'b1;
            held_next   = held_reg;
            sum_next    = sum_reg + SUM_W'(sample) - SUM_W'(old_value);
        end else begin
            oldest_next = oldest_reg;
            held_next   = held_reg + 1'b1;
            sum_next    = sum_reg + SUM_W'(sample);
        end
    end

    // window storage, written once per transaction
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[slot] <= sample;
        end
    end

    // occupancy, ring pointer and running sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            held_reg   <= '0;
            sum_reg    <= '0;
        end else if (push) begin
            oldest_reg <= oldest_next;
            held_reg   <= held_next;
            sum_reg    <= sum_next;
        end
    end

    assign held_count = held_reg;

endmodule : wma_window

`default_nettype wire

### design/wma_div.sv
`default_nettype none

module wma_div
    import wma_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DVD_W-1:0]  dividend,
    input  wire logic [CNT_W-1:0]  divisor,
    output wma_div_stat_t          stat,
    output logic      [MEAN_W-1:0] quotient
);

    logic [DVD_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [MEAN_W-1:0] quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W+1:0]  diff;
    logic              qbit;
    logic [CNT_W-1:0]  rem_next;

    // one restoring step: bring down the next dividend bit, try the subtract
    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = {1'b0, rem_sh} - {2'b00, dsr_reg};
        qbit     = !diff[CNT_W+1];
        rem_next = qbit ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end

    // shift registers for dividend, remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[MEAN_W-2:0], qbit};
        end
    end

    // step counter and status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            step_reg <= STEP_W'(DVD_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            busy_reg <= (step_reg != STEP_W'(1));
            done_reg <= (step_reg == STEP_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule : wma_div

`default_nettype wire

### design/windowed_moving_average.sv
// windowed moving average over the last five unsigned 16-bit samples
//
// input channel s_valid/s_ready/s_sample: one transaction pushes one sample;
// once the window is full the oldest sample is dropped.
// result channel m_valid/m_ready/m_fill_count/m_mean_fixed: one transaction
// per input transaction, giving the samples held and their mean with 8
// fraction bits, truncated.
// the mean comes from a restoring divider that yields one quotient
// bit per cycle over the 27-bit scaled sum; the divider is the only
// serial unit and handles one sample at a time, so the next sample is
// taken only once the previous result has entered the output register.
// the result sits in an output register, so a new sample is taken while the
// previous result still waits. if the receiver stalls longer than one item,
// the finished quotient is held in the divider and the input stays blocked
// until the output register frees up.
// reset (aresetn low, synchronous) empties the window, clears the running
// sum and drops any pending result.
`default_nettype none

module windowed_moving_average
    import wma_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [SAMPLE_W-1:0] s_sample,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [FILL_W-1:0]   m_fill_count,
    output logic      [MEAN_W-1:0]   m_mean_fixed
);

    wma_state_t     state_reg;
    wma_state_t     state_next;
    logic           accept;
    logic           load_out;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  held_next;
    logic [CNT_W-1:0]  held_count;
    wma_div_stat_t  div_stat;
    logic [MEAN_W-1:0] quotient;
    logic              m_valid_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [MEAN_W-1:0] mean_reg;

    assign accept = s_valid && s_ready;

    // sample window and running sum
    wma_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .sample     (s_sample),
        .sum_next   (sum_next),
        .held_next  (held_next),
        .held_count (held_count)
    );

    // serial divider for sum * 256 / count
    wma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend ({sum_next, FRAC_W'(0)}),
        .divisor  (held_next),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // control state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and output register load
    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_stat.done) begin
                    if (!m_valid_reg || m_ready) begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            fill_reg <= FILL_W'(held_count);
            mean_reg <= quotient;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_fill_count = fill_reg;
    assign m_mean_fixed = mean_reg;

`ifndef SYNTHESIS
    // a result only appears once the divider has finished
    a_result_after_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_DIVIDE || $past(state_reg) == ST_HOLD))
        else $error("result raised without a finished division");

    // the divider is never running while new samples are taken
    a_div_idle_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !div_stat.busy)
        else $error("sample accepted while divider busy");

    // occupancy never exceeds the window depth
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count <= CNT_W'(WINDOW))
        else $error("window occupancy out of range");

    // a waiting result is not overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_mean_fixed) && $stable(m_fill_count))
        else $error("pending result changed");
`endif

endmodule : windowed_moving_average

`default_nettype wire

### test/windowed_moving_average_tb.sv
`timescale 1ns / 1ps

module windowed_moving_average_tb;
    import wma_pkg::*;

    localparam int DIRECTED_N  = 18;
    localparam int RANDOM_N    = 500;
    localparam int BURST_LO    = 200;   // sender sends back to back in this range
    localparam int BURST_HI    = 260;
    localparam int DRAIN_AT    = 350;   // sender waits for every result here
    localparam int HOLD_AT     = 120;   // receiver holds off once, at this result
    localparam int HOLD_CYCLES = 300;
    localparam int STEADY_LO   = 300;   // receiver never stalls in this range
    localparam int STEADY_HI   = 380;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [MEAN_W-1:0] mean;
    } average_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                typed;
        average_t            want;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample;
    logic                m_valid;
    logic                m_ready;
    logic [FILL_W-1:0]   m_fill_count;
    logic [MEAN_W-1:0]   m_mean_fixed;

    // predictor state: a copy of the sample window
    logic [SAMPLE_W-1:0] window_samples [WINDOW];
    int unsigned         window_head;
    int unsigned         window_depth;
    logic [SUM_W-1:0]    window_total;

    average_t  pending_averages [$];
    stim_row_t stim_table [DIRECTED_N];
    int        samples_sent;
    int        results_taken;
    int        errors;

    windowed_moving_average uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fill_count (m_fill_count),
        .m_mean_fixed (m_mean_fixed)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic stim_row_t row(input logic [SAMPLE_W-1:0] sample, input logic typed,
                                      input logic [FILL_W-1:0] fill,
                                      input logic [MEAN_W-1:0] mean);
        stim_row_t r;
        r.sample    = sample;
        r.typed     = typed;
        r.want.fill = fill;
        r.want.mean = mean;
        return r;
    endfunction

    // push one sample into the window copy and compute the mean it yields
    task automatic advance_window(input logic [SAMPLE_W-1:0] sample, output average_t avg);
        int unsigned      slot;
        logic [DVD_W-1:0] scaled;
        logic [DVD_W-1:0] quotient;
        if (window_depth >= WINDOW) begin
            // full: the oldest sample leaves, its slot takes the new one
            slot         = window_head;
            window_total = window_total - window_samples[slot];
            window_head  = (slot + 1) % WINDOW;
        end else begin
            slot         = (window_head + window_depth) % WINDOW;
            window_depth = window_depth + 1;
        end
        window_samples[slot] = sample;
        window_total         = window_total + sample;
        scaled   = DVD_W'(window_total) << FRAC_W;
        quotient = scaled / DVD_W'(window_depth);
        avg.fill = FILL_W'(window_depth);
        avg.mean = MEAN_W'(quotient);
    endtask

    // offer one sample transaction after a random gap, or with no gap in the burst range
    task automatic push_sample(input logic [SAMPLE_W-1:0] value, input logic typed,
                               input average_t typed_avg);
        int       gap;
        average_t predicted;
        gap = (samples_sent >= BURST_LO && samples_sent < BURST_HI) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        advance_window(value, predicted);
        pending_averages.push_back(typed ? typed_avg : predicted);
        samples_sent++;
    endtask

    // main stimulus
    initial begin
        logic [SAMPLE_W-1:0] value;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_sample     <= '0;
        samples_sent  = 0;
        errors        = 0;
        window_head   = 0;
        window_depth  = 0;
        window_total  = '0;
        for (int i = 0; i < WINDOW; i++) window_samples[i] = '0;

        // directed rows: extremes, filling, wrap, and mixed bit patterns
        stim_table[0]  = row(16'hFFFF, 1'b1, 3'd1, 24'd16776960);
        stim_table[1]  = row(16'h0000, 1'b1, 3'd2, 24'd8388480);
        stim_table[2]  = row(16'hFFFF, 1'b0, '0, '0);
        stim_table[3]  = row(16'hFFFF, 1'b0, '0, '0);
        stim_table[4]  = row(16'hFFFF, 1'b0, '0, '0);
        stim_table[5]  = row(16'hFFFF, 1'b0, '0, '0);
        stim_table[6]  = row(16'hFFFF, 1'b1, 3'd5, 24'd16776960);
        stim_table[7]  = row(16'h0000, 1'b0, '0, '0);
        stim_table[8]  = row(16'h0000, 1'b0, '0, '0);
        stim_table[9]  = row(16'h0000, 1'b0, '0, '0);
        stim_table[10] = row(16'h0000, 1'b0, '0, '0);
        stim_table[11] = row(16'h0000, 1'b1, 3'd5, 24'd0);
        stim_table[12] = row(16'h0001, 1'b0, '0, '0);
        stim_table[13] = row(16'hAAAA, 1'b0, '0, '0);
        stim_table[14] = row(16'h5555, 1'b0, '0, '0);
        stim_table[15] = row(16'h8000, 1'b0, '0, '0);
        stim_table[16] = row(16'h7FFF, 1'b0, '0, '0);
        stim_table[17] = row(16'h0001, 1'b0, '0, '0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++) begin
            push_sample(stim_table[i].sample, stim_table[i].typed, stim_table[i].want);
        end

        // random samples, with extremes mixed in
        for (int i = 0; i < RANDOM_N; i++) begin
            if (i == DRAIN_AT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_averages.size() != 0) @(posedge aclk);
            end
            case ($urandom_range(0, 9))
                0:       value = '0;
                1:       value = '1;
                default: value = SAMPLE_W'($urandom);
            endcase
            push_sample(value, 1'b0, '0);
        end
        s_valid <= 1'b0;

        // wait for the last results, then watch for strays
        while (pending_averages.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // result receiver: random stalls, one long hold-off, one steady stretch
    initial begin
        int stall;
        m_ready      <= 1'b0;
        results_taken = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (results_taken == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end else if (results_taken >= STEADY_LO && results_taken < STEADY_HI) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 15);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            results_taken++;
        end
    end

    // compare each result transaction with the oldest expected average
    always @(posedge aclk) begin : check_results
        average_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_averages.size() == 0) begin
                $error("unexpected result: fill_count %0d mean_fixed %0d",
                       m_fill_count, m_mean_fixed);
                errors++;
            end else begin
                want = pending_averages.pop_front();
                if (m_fill_count !== want.fill) begin
                    $error("fill_count mismatch: expected %0d, actual %0d",
                           want.fill, m_fill_count);
                    errors++;
                end
                if (m_mean_fixed !== want.mean) begin
                    $error("mean_fixed mismatch: expected %0d, actual %0d",
                           want.mean, m_mean_fixed);
                    errors++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
